@@ rtl/byte_segment_stack_two_widths_top_defines.svh @@
// Assertion macros for the byte segment stack checker.
// Used only by bsstw_checker; needs nothing else.
`ifndef BYTE_SEGMENT_STACK_TWO_WIDTHS_TOP_DEFINES_SVH
`define BYTE_SEGMENT_STACK_TWO_WIDTHS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BSSTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BSSTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsstw_pkg.sv @@
// Shared types and constants for the byte segment stack.
// No dependencies; imported by every module of the block.
package bsstw_pkg;

    localparam int SEG_BYTES_DEF = 1024;
    localparam int BANKS         = 8;
    localparam int CFG_W         = 11;
    localparam int POS_W         = 12;
    localparam int COUNT_W       = 9;
    localparam int DATA_W        = 40;
    localparam int ENTRY_MAX     = 5;

    localparam logic [2:0]         VAR_BYTES        = 3'd5;
    localparam logic [2:0]         REF_BYTES        = 3'd4;
    localparam logic [DATA_W-1:0]  FAIL_VAR         = 40'h00_0000_0023;
    localparam logic [DATA_W-1:0]  FAIL_REF         = 40'h00_FFFF_FFFF;
    localparam logic [POS_W-1:0]   POS_FAIL         = 12'hFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 9'h1FF;
    localparam logic [CFG_W-1:0]   STACK_SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_PUSH_VAR = 2'd0,
        FUNC_PUSH_REF = 2'd1,
        FUNC_POP_VAR  = 2'd2,
        FUNC_POP_REF  = 2'd3
    } func_t;

    // Per-request result data carried from issue to the output stage
    typedef struct packed {
        logic               is_pop;
        logic               is_var;
        logic               ok;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic [2:0]         base_lo;
    } meta_t;

endpackage

@@ rtl/bsstw_bank.sv @@
// One byte lane of the segment memory: synchronous write, registered read.
// Depends on bsstw_pkg only through the module header import.
module bsstw_bank
    import bsstw_pkg::*;
#(
    parameter int ROWS = SEG_BYTES_DEF / BANKS,
    parameter int RW   = 7
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [RW-1:0] row,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[row] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bsstw_ctrl.sv @@
// Stack control: size register, top pointer, entry count, bank address
// generation and per-request result data. Depends on bsstw_pkg.
module bsstw_ctrl
    import bsstw_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEG_BYTES_DEF,
    parameter int TW            = 11,
    parameter int RW            = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               fire,
    input  func_t              func,
    input  logic [DATA_W-1:0]  push_data,
    output logic [BANKS-1:0]   bank_we,
    output logic [BANKS-1:0]   bank_re,
    output logic [RW-1:0]      bank_row   [BANKS],
    output logic [7:0]         bank_wdata [BANKS],
    output meta_t              meta
);

    localparam int CW = ((TW > CFG_W) ? TW : CFG_W) + 1;

    logic [CFG_W-1:0]   stack_size_reg;
    logic [TW-1:0]      top_reg;
    logic [TW-1:0]      top_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    meta_t              meta_reg;
    meta_t              meta_next;

    logic          is_push;
    logic          is_var;
    logic [2:0]    nbytes;
    logic [CW-1:0] top_ext;
    logic [CW-1:0] size_ext;
    logic [CW-1:0] limit;
    logic [CW-1:0] pos_var;
    logic          push_fit;
    logic          pop_fit;
    logic          op_ok;
    logic [TW-1:0] base;
    logic [7:0]    pbyte [BANKS];
    logic [2:0]    off   [BANKS];
    logic [TW:0]   rsum  [BANKS];

    always_comb
    begin
        is_push  = func inside {FUNC_PUSH_VAR, FUNC_PUSH_REF};
        is_var   = func inside {FUNC_PUSH_VAR, FUNC_POP_VAR};
        nbytes   = is_var ? VAR_BYTES : REF_BYTES;
        top_ext  = CW'(top_reg);
        size_ext = CW'(stack_size_reg);
        limit    = (size_ext < CW'(SEGMENT_BYTES)) ? size_ext : CW'(SEGMENT_BYTES);
        push_fit = (top_ext + CW'(nbytes)) <= limit;
        pop_fit  = top_ext >= CW'(nbytes);
        op_ok    = is_push ? push_fit : pop_fit;
        pos_var  = top_ext + CW'(1);

        // Push writes at the old top; pop reads from the lowered top
        base     = is_push ? top_reg : (top_reg - TW'(nbytes));
        top_next = is_push ? (top_reg + TW'(nbytes)) : base;

        count_next = count_reg;
        if (op_ok)
        begin
            if (is_push && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            else if (!is_push && (count_reg != '0))
            begin
                count_next = count_reg - COUNT_W'(1);
            end
        end

        meta_next.is_pop   = !is_push;
        meta_next.is_var   = is_var;
        meta_next.ok       = op_ok;
        meta_next.count    = count_next;
        meta_next.base_lo  = base[2:0];
        if (!is_push)
        begin
            meta_next.position = '0;
        end
        else if (!push_fit)
        begin
            meta_next.position = POS_FAIL;
        end
        else if (is_var)
        begin
            meta_next.position = pos_var[POS_W-1:0];
        end
        else
        begin
            meta_next.position = top_ext[POS_W-1:0];
        end

        for (int i = 0; i < BANKS; i++)
        begin
            pbyte[i] = 8'h00;
        end
        for (int i = 0; i < ENTRY_MAX; i++)
        begin
            pbyte[i] = push_data[8*i +: 8];
        end

        // Byte i of the entry lives in bank (base + i) mod 8
        for (int k = 0; k < BANKS; k++)
        begin
            off[k]        = 3'(k) - base[2:0];
            rsum[k]       = (TW+1)'(base) + (TW+1)'(off[k]);
            bank_row[k]   = rsum[k][RW+2:3];
            bank_wdata[k] = pbyte[off[k]];
            bank_we[k]    = fire && is_push && push_fit && (off[k] < nbytes);
            bank_re[k]    = fire && !is_push && pop_fit && (off[k] < nbytes);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_size_reg <= STACK_SIZE_RESET;
            top_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                stack_size_reg <= cfg_wr_data;
            end
            if (fire && op_ok)
            begin
                top_reg   <= top_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            meta_reg <= meta_next;
        end
    end

    assign meta = meta_reg;

endmodule

@@ rtl/byte_segment_stack_two_widths_top.sv @@
// Byte-addressed stack with 5-byte variable and 4-byte reference entries.
// An accepted request issues the registered bank read; the output register then loads
// the result from the read stage. Throughput: one request per cycle while in_stall is
// low, set by the eight byte banks that serve any 5-byte access in a single read or
// write. Reset clears the top pointer, entry count, stack size (to 1024) and pipeline
// valids; the memory is not cleared.
module byte_segment_stack_two_widths_top
    import bsstw_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEG_BYTES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [DATA_W-1:0]        push_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  position,
    output logic [DATA_W-1:0]        pop_data,
    output logic                     ok,
    output logic [COUNT_W-1:0]       element_count
);

    // Top pointer spans 0..SEGMENT_BYTES; each bank holds one byte per row
    localparam int TW   = $clog2(SEGMENT_BYTES + 1);
    localparam int ROWS = (SEGMENT_BYTES + BANKS - 1) / BANKS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic               fire;
    logic               s1_adv;
    logic               s1_valid_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   position_reg;
    logic [DATA_W-1:0]  pop_data_reg;
    logic               ok_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DATA_W-1:0]  pop_data_next;
    logic [DATA_W-1:0]  popped;

    logic [BANKS-1:0] bank_we;
    logic [BANKS-1:0] bank_re;
    logic [RW-1:0]    bank_row   [BANKS];
    logic [7:0]       bank_wdata [BANKS];
    logic [7:0]       bank_rdata [BANKS];
    meta_t            meta;

    // The read stage moves on when the output register is empty or drained;
    // hold new requests off only while it is stuck.
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign fire     = in_valid && !in_stall;

    bsstw_ctrl #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .TW            (TW),
        .RW            (RW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .func        (func_t'(func)),
        .push_data   (push_data),
        .bank_we     (bank_we),
        .bank_re     (bank_re),
        .bank_row    (bank_row),
        .bank_wdata  (bank_wdata),
        .meta        (meta)
    );

    // Read data holds in the banks while the read stage waits: no new read
    // is issued until the stage drains.
    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        bsstw_bank #(
            .ROWS (ROWS),
            .RW   (RW)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .re    (bank_re[g]),
            .row   (bank_row[g]),
            .wdata (bank_wdata[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Rotate bank bytes back into entry order: byte i came from bank base+i
    always_comb
    begin
        popped = '0;
        for (int i = 0; i < ENTRY_MAX; i++)
        begin
            popped[8*i +: 8] = bank_rdata[3'(meta.base_lo + 3'(i))];
        end
        if (!meta.is_var)
        begin
            popped[DATA_W-1:32] = '0;
        end

        // Failed pops return a fixed pattern; pushes return zero
        if (!meta.is_pop)
        begin
            pop_data_next = '0;
        end
        else if (meta.ok)
        begin
            pop_data_next = popped;
        end
        else if (meta.is_var)
        begin
            pop_data_next = FAIL_VAR;
        end
        else
        begin
            pop_data_next = FAIL_REF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= fire || (s1_valid_reg && !s1_adv);
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Advance the output payload only when the read stage hands over
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            position_reg <= meta.position;
            pop_data_reg <= pop_data_next;
            ok_reg       <= meta.ok;
            count_reg    <= meta.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign pop_data      = pop_data_reg;
    assign ok            = ok_reg;
    assign element_count = count_reg;

endmodule

@@ rtl/bsstw_checker.sv @@
// Port-level checker for the byte segment stack, bound to the top level.
// Depends on bsstw_pkg and byte_segment_stack_two_widths_top_defines.svh.
`include "byte_segment_stack_two_widths_top_defines.svh"

module bsstw_checker
    import bsstw_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [1:0]               func,
    input logic [DATA_W-1:0]        push_data,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [POS_W-1:0]  position,
    input logic [DATA_W-1:0]        pop_data,
    input logic                     ok,
    input logic [COUNT_W-1:0]       element_count
);

    // A stalled request must hold
    `BSSTW_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(func) && $stable(push_data), "stalled request changed")

    // A stalled result must hold
    `BSSTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pop_data) && $stable(position) && $stable(element_count), "stalled result changed")

    // A failure is either a push overflow or one of the two pop patterns
    `BSSTW_ASSERT_NOW(a_fail_shape, clk, rst_n, out_valid && !ok, (position == POS_FAIL && pop_data == '0) || (position == '0 && (pop_data == FAIL_VAR || pop_data == FAIL_REF)), "bad failure result")

    // Popped data only comes with position zero
    `BSSTW_ASSERT_NOW(a_pop_pos, clk, rst_n, out_valid && pop_data != '0, position == '0, "pop with nonzero position")

    // A successful push never reports the overflow position
    `BSSTW_ASSERT_NOW(a_push_pos, clk, rst_n, out_valid && ok && pop_data == '0 && position != '0, position != POS_FAIL, "push success with overflow position")

endmodule

bind byte_segment_stack_two_widths_top bsstw_checker u_bsstw_checker (.*);
